// ----- hdl/pbo_pkg.sv -----
// ----------------------------------------------------------------------------
// pbo_pkg - shared types and constants of the PolyBLEP oscillator
// Waveform codes, sequencer states, fixed-point constants and helpers.
// ----------------------------------------------------------------------------
package pbo_pkg;

  // Default accumulator width
  localparam int PhaseBitsDef = 24;

  // Configuration port
  localparam int PaddrWidth = 3;
  localparam int PdataWidth = 32;
  localparam logic RegWaveform  = 1'b0;
  localparam logic RegPhaseStep = 1'b1;

  // Fixed-point constants (amplitude one = 2^20, phase one = 2^24)
  localparam int QuotBits = 20;
  localparam int PwGain   = 15099494;
  localparam int PwMin    = 838861;
  localparam int PwMax    = 15938355;
  localparam int Leak     = 16760439;
  localparam int PwHalf   = 8388608;
  localparam int AmpOne   = 1048576;
  localparam int SatHi    = 8388607;
  localparam int SatLo    = -8388608;

  // Shared multiplier operand and product widths
  localparam int MulAW = 27;
  localparam int MulBW = 25;
  localparam int MulPW = MulAW + MulBW;

  typedef enum logic [1:0] {
    WaveSaw   = 2'd0,
    WavePulse = 2'd1,
    WaveTri   = 2'd2,
    WaveMute  = 2'd3
  } wave_e;

  typedef enum logic [3:0] {
    StIdle,
    StStart,
    StPw,
    StBase,
    StBlep,
    StDiv,
    StSq0,
    StSq1,
    StInt0,
    StInt1,
    StInt2,
    StInt3,
    StDone
  } state_e;

  typedef struct packed {
    logic [1:0]  waveform;
    logic [23:0] phase_step;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [23:0] num;
    logic [23:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [QuotBits-1:0] quot;
  } div_rsp_t;

  // Signed shift right by sh, rounding toward zero
  function automatic logic signed [MulPW-1:0] trunc_shr(input logic signed [MulPW-1:0] v,
                                                       input int unsigned sh);
    logic signed [MulPW-1:0] bias;
    bias = v[MulPW-1] ? ((MulPW'(1) <<< sh) - MulPW'(1)) : '0;
    return (v + bias) >>> sh;
  endfunction

  // Saturate to the signed Q3.20 range
  function automatic logic signed [23:0] sat24(input logic signed [MulPW-1:0] v);
    logic signed [23:0] r;
    if (v > MulPW'(SatHi)) r = 24'(SatHi);
    else if (v < MulPW'(SatLo)) r = 24'(SatLo);
    else r = 24'(v);
    return r;
  endfunction

endpackage

// ----- hdl/pbo_in_if.sv -----
// ----------------------------------------------------------------------------
// pbo_in_if - sample tick channel
// Carries one word per sample: FM phase offset and shape modulation.
// ----------------------------------------------------------------------------
interface pbo_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] phase_offset;
  logic [15:0] shape_mod;

  modport source (output valid, output phase_offset, output shape_mod, input ready);
  modport sink   (input valid, input phase_offset, input shape_mod, output ready);
endinterface

// ----- hdl/pbo_out_if.sv -----
// ----------------------------------------------------------------------------
// pbo_out_if - output sample channel
// Carries one signed Q3.20 sample word.
// ----------------------------------------------------------------------------
interface pbo_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- hdl/pbo_divider.sv -----
// ----------------------------------------------------------------------------
// pbo_divider - serial fractional divider
// Computes floor(num * 2^20 / den) for num < den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pbo_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pbo_pkg::div_req_t  req_i,
  output pbo_pkg::div_rsp_t  rsp_o
);

  localparam int CntW = $clog2(pbo_pkg::QuotBits);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [23:0]                  rem_q, rem_d;
  logic [23:0]                  den_q, den_d;
  logic [pbo_pkg::QuotBits-1:0] quot_q, quot_d;
  logic [24:0]                  rem2;

  // One restoring step a cycle
  always_comb begin
    rem2   = {rem_q, 1'b0};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.num;
      den_d  = req_i.den;
      quot_d = '0;
    end else if (busy_q) begin
      if (rem2 >= {1'b0, den_q}) begin
        rem_d  = 24'(rem2 - {1'b0, den_q});
        quot_d = {quot_q[pbo_pkg::QuotBits-2:0], 1'b1};
      end else begin
        rem_d  = rem2[23:0];
        quot_d = {quot_q[pbo_pkg::QuotBits-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(pbo_pkg::QuotBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ----- hdl/pbo_mul.sv -----
// ----------------------------------------------------------------------------
// pbo_mul - shared signed multiplier
// One registered signed product, used for pulse width, squares and integrator.
// ----------------------------------------------------------------------------
module pbo_mul (
  input  logic                              clk_i,
  input  logic signed [pbo_pkg::MulAW-1:0]  a_i,
  input  logic signed [pbo_pkg::MulBW-1:0]  b_i,
  output logic signed [pbo_pkg::MulPW-1:0]  prod_o
);

  logic signed [pbo_pkg::MulPW-1:0] prod_q;

  // Product registered, ready in the cycle after the operands
  always_ff @(posedge clk_i) begin
    prod_q <= pbo_pkg::MulPW'(a_i) * pbo_pkg::MulPW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ----- hdl/pbo_apb_regs.sv -----
// ----------------------------------------------------------------------------
// pbo_apb_regs - configuration registers
// APB-style write and read of waveform and phase step.
// ----------------------------------------------------------------------------
module pbo_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pbo_pkg::PaddrWidth-1:0] paddr,
  input  logic [pbo_pkg::PdataWidth-1:0] pwdata,
  output logic [pbo_pkg::PdataWidth-1:0] prdata,
  output logic                           pready,
  output pbo_pkg::cfg_t                  cfg_o
);

  logic [1:0]  waveform_q, waveform_d;
  logic [23:0] phase_step_q, phase_step_d;
  logic        wr_en;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  // Write decode
  always_comb begin
    waveform_d   = waveform_q;
    phase_step_d = phase_step_q;
    if (wr_en) begin
      case (reg_idx)
        pbo_pkg::RegWaveform:  waveform_d   = pwdata[1:0];
        pbo_pkg::RegPhaseStep: phase_step_d = pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      pbo_pkg::RegWaveform:  prdata = {30'b0, waveform_q};
      pbo_pkg::RegPhaseStep: prdata = {8'b0, phase_step_q};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q   <= '0;
      phase_step_q <= '0;
    end else begin
      waveform_q   <= waveform_d;
      phase_step_q <= phase_step_d;
    end
  end

  assign cfg_o.waveform   = waveform_q;
  assign cfg_o.phase_step = phase_step_q;

endmodule

// ----- hdl/polyblep_oscillator.sv -----
// ----------------------------------------------------------------------------
// polyblep_oscillator - band-limited saw, pulse and triangle oscillator
// Phase accumulator with PolyBLEP edge correction and a leaky integrator.
// ----------------------------------------------------------------------------
// Sequence: Start, Pw (pulse), Base (pulse, triangle), Blep, then Div, Sq0
// and Sq1 for each corrected edge (up to two), Int0 to Int3 (triangle) and
// Done, which loads the output register and waits while the output stalls;
// the silent code goes from Start to Done. A new word is taken only in Idle,
// after the output register loads; the serial divider dominates.
// Reset clears phase, integrator, sequencer state and the output valid flag.
// ----------------------------------------------------------------------------
module polyblep_oscillator #(
  parameter int PhaseBits = pbo_pkg::PhaseBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pbo_in_if.sink                         in_i,
  pbo_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pbo_pkg::PaddrWidth-1:0] paddr,
  input  logic [pbo_pkg::PdataWidth-1:0] pwdata,
  output logic [pbo_pkg::PdataWidth-1:0] prdata,
  output logic                           pready
);

  localparam int AlignSh = (PhaseBits >= 24) ? PhaseBits - 24 : 24 - PhaseBits;
  localparam int AW = pbo_pkg::MulAW;
  localparam int BW = pbo_pkg::MulBW;
  localparam int PW = pbo_pkg::MulPW;

  pbo_pkg::cfg_t     cfg;
  pbo_pkg::div_req_t div_req;
  pbo_pkg::div_rsp_t div_rsp;

  pbo_pkg::state_e      state_q, state_d;
  logic [PhaseBits-1:0] phase_acc_q, phase_acc_d;
  logic signed [23:0]   integ_q, integ_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [23:0]   sample_q, sample_d;
  logic [23:0]          t_q, t_d;
  logic [23:0]          dt_q, dt_d;
  logic [15:0]          mod_q, mod_d;
  logic [1:0]           wf_q, wf_d;
  logic [23:0]          pw_q, pw_d;
  logic signed [AW-1:0] r_q, r_d;
  logic                 bidx_q, bidx_d;
  logic                 blep_lo_q, blep_lo_d;

  logic                 accept;
  logic [PhaseBits-1:0] off_acc, step_acc, tp;
  logic [23:0]          t_new;
  logic [23:0]          sel_s;
  logic                 s_lt;
  logic                 s_hi;
  logic [23:0]          s_y;
  logic [20:0]          u;
  logic signed [AW-1:0] mag;
  logic signed [24:0]   d_pw;
  logic signed [PW-1:0] pw_full;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [23:0]   integ_new;

  pbo_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pbo_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pbo_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Alignment between the accumulator and the Q0.24 waveform phase
  generate
    if (PhaseBits >= 24) begin : g_wide
      assign off_acc  = PhaseBits'(in_i.phase_offset) << AlignSh;
      assign step_acc = PhaseBits'(cfg.phase_step) << AlignSh;
      assign t_new    = 24'(tp >> AlignSh);
    end else begin : g_narrow
      assign off_acc  = PhaseBits'(in_i.phase_offset >> AlignSh);
      assign step_acc = PhaseBits'(cfg.phase_step >> AlignSh);
      assign t_new    = 24'(tp) << AlignSh;
    end
  endgenerate

  assign tp     = phase_acc_q + off_acc;
  assign accept = in_i.valid && in_i.ready;

  // Edge test for the phase under correction
  assign sel_s = bidx_q ? 24'(t_q - pw_q) : t_q;
  assign s_lt  = sel_s < dt_q;
  assign s_hi  = ({1'b0, sel_s} + {1'b0, dt_q}) > 25'h1000000;
  assign s_y   = 24'(25'h1000000 - {1'b0, sel_s});

  assign u    = 21'(pbo_pkg::AmpOne) - {1'b0, div_rsp.quot};
  assign mag  = $signed({6'b0, prod[40:20]});
  assign d_pw = $signed({1'b0, mod_q, 8'h00}) - 25'sd8388608;

  assign pw_full   = PW'(pbo_pkg::PwHalf) + pbo_pkg::trunc_shr(prod, 24);
  assign integ_new = pbo_pkg::sat24(pbo_pkg::trunc_shr(prod, 24));

  // Sequencer: next state, datapath and multiplier operands
  always_comb begin
    state_d     = state_q;
    phase_acc_d = phase_acc_q;
    integ_d     = integ_q;
    out_valid_d = out_valid_q && !out_o.ready;
    sample_d    = sample_q;
    t_d         = t_q;
    dt_d        = dt_q;
    mod_d       = mod_q;
    wf_d        = wf_q;
    pw_d        = pw_q;
    r_d         = r_q;
    bidx_d      = bidx_q;
    blep_lo_d   = blep_lo_q;
    in_i.ready  = 1'b0;
    div_req     = '0;
    div_req.den = dt_q;
    mul_a       = '0;
    mul_b       = '0;

    case (state_q)
      pbo_pkg::StIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          t_d         = t_new;
          dt_d        = cfg.phase_step;
          mod_d       = in_i.shape_mod;
          wf_d        = cfg.waveform;
          phase_acc_d = phase_acc_q + step_acc;
          state_d     = pbo_pkg::StStart;
        end
      end
      pbo_pkg::StStart: begin
        bidx_d = 1'b0;
        case (pbo_pkg::wave_e'(wf_q))
          pbo_pkg::WaveSaw: begin
            r_d     = $signed({6'b0, t_q[23:3]}) - AW'(pbo_pkg::AmpOne);
            state_d = pbo_pkg::StBlep;
          end
          pbo_pkg::WavePulse: begin
            mul_a   = AW'(d_pw);
            mul_b   = BW'(pbo_pkg::PwGain);
            state_d = pbo_pkg::StPw;
          end
          pbo_pkg::WaveTri: begin
            pw_d    = 24'(pbo_pkg::PwHalf);
            state_d = pbo_pkg::StBase;
          end
          default: begin
            r_d     = '0;
            state_d = pbo_pkg::StDone;
          end
        endcase
      end
      pbo_pkg::StPw: begin
        if (pw_full < PW'(pbo_pkg::PwMin)) pw_d = 24'(pbo_pkg::PwMin);
        else if (pw_full > PW'(pbo_pkg::PwMax)) pw_d = 24'(pbo_pkg::PwMax);
        else pw_d = 24'(pw_full);
        state_d = pbo_pkg::StBase;
      end
      pbo_pkg::StBase: begin
        r_d     = (t_q < pw_q) ? AW'(pbo_pkg::AmpOne) : -AW'(pbo_pkg::AmpOne);
        state_d = pbo_pkg::StBlep;
      end
      pbo_pkg::StBlep: begin
        if (s_lt) begin
          div_req.start = 1'b1;
          div_req.num   = sel_s;
          blep_lo_d     = 1'b1;
          state_d       = pbo_pkg::StDiv;
        end else if (s_hi) begin
          div_req.start = 1'b1;
          div_req.num   = s_y;
          blep_lo_d     = 1'b0;
          state_d       = pbo_pkg::StDiv;
        end else if (wf_q != pbo_pkg::WaveSaw && !bidx_q) begin
          bidx_d  = 1'b1;
        end else if (wf_q == pbo_pkg::WaveTri) begin
          state_d = pbo_pkg::StInt0;
        end else begin
          state_d = pbo_pkg::StDone;
        end
      end
      pbo_pkg::StDiv: begin
        if (div_rsp.done) state_d = pbo_pkg::StSq0;
      end
      pbo_pkg::StSq0: begin
        mul_a   = $signed({6'b0, u});
        mul_b   = $signed({4'b0, u});
        state_d = pbo_pkg::StSq1;
      end
      pbo_pkg::StSq1: begin
        // Lower-edge BLEP is negative and upper-edge positive; the signs flip for saw and the pulse-width edge
        if (blep_lo_q ^ (wf_q == pbo_pkg::WaveSaw || bidx_q)) r_d = r_q - mag;
        else r_d = r_q + mag;
        if (wf_q != pbo_pkg::WaveSaw && !bidx_q) begin
          bidx_d  = 1'b1;
          state_d = pbo_pkg::StBlep;
        end else if (wf_q == pbo_pkg::WaveTri) begin
          state_d = pbo_pkg::StInt0;
        end else begin
          state_d = pbo_pkg::StDone;
        end
      end
      pbo_pkg::StInt0: begin
        mul_a   = r_q;
        mul_b   = $signed({1'b0, dt_q});
        state_d = pbo_pkg::StInt1;
      end
      pbo_pkg::StInt1: begin
        r_d     = AW'(integ_q) + AW'(pbo_pkg::trunc_shr(prod, 22));
        state_d = pbo_pkg::StInt2;
      end
      pbo_pkg::StInt2: begin
        mul_a   = r_q;
        mul_b   = BW'(pbo_pkg::Leak);
        state_d = pbo_pkg::StInt3;
      end
      pbo_pkg::StInt3: begin
        integ_d = integ_new;
        r_d     = AW'(integ_new);
        state_d = pbo_pkg::StDone;
      end
      pbo_pkg::StDone: begin
        if (!out_valid_q || out_o.ready) begin
          sample_d    = pbo_pkg::sat24(PW'(r_q));
          out_valid_d = 1'b1;
          state_d     = pbo_pkg::StIdle;
        end
      end
      default: state_d = pbo_pkg::StIdle;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbo_pkg::StIdle;
      phase_acc_q <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_acc_q <= phase_acc_d;
      integ_q     <= integ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    t_q       <= t_d;
    dt_q      <= dt_d;
    mod_q     <= mod_d;
    wf_q      <= wf_d;
    pw_q      <= pw_d;
    r_q       <= r_d;
    bidx_q    <= bidx_d;
    blep_lo_q <= blep_lo_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.sample = sample_q;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("input still ready after a word was taken");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == pbo_pkg::StDiv)
    else $error("divider finished outside its wait state");

  a_integ_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(integ_q) |-> $past(state_q) == pbo_pkg::StInt3)
    else $error("integrator changed outside the leak step");

  a_phase_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(phase_acc_q) |-> $past(accept))
    else $error("phase advanced without a sample tick");

endmodule
